/* rtl/sdds_pkg.sv */
`timescale 1ns / 1ps

package sdds_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STEP_W     = 32;

  // Q0.15 sine magnitude, sign carried separately
  localparam int unsigned SINE_W = 15;
  localparam int unsigned Q_SHIFT = 15;

  // pi/2 in Q30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic [STEP_W-1:0] PHASE_STEP_RST = 32'd21474836;
  localparam logic [31:0]       LEVEL_RST      = 32'd2048;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP = 2'd0,
    REG_AMPLITUDE  = 2'd1,
    REG_OFFSET     = 2'd2,
    REG_RUN        = 2'd3
  } cfg_reg_e;

  // advance enables of the three pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

  // quarter-wave entry: Taylor series through x^15 in Q30, rounded to Q15
  function automatic logic [SINE_W-1:0] rom_entry(int unsigned idx, int unsigned addr_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          s;
    longint          q;
    x  = (HALF_PI_Q30 * (64'(idx) * 64'd2 + 64'd1)) >> (addr_bits + 1);
    x2 = (x * x) >> 30;
    t  = x;
    s  = longint'(x);
    t  = ((t * x2) >> 30) / 6;
    s  = s - longint'(t);
    t  = ((t * x2) >> 30) / 20;
    s  = s + longint'(t);
    t  = ((t * x2) >> 30) / 42;
    s  = s - longint'(t);
    t  = ((t * x2) >> 30) / 72;
    s  = s + longint'(t);
    t  = ((t * x2) >> 30) / 110;
    s  = s - longint'(t);
    t  = ((t * x2) >> 30) / 156;
    s  = s + longint'(t);
    t  = ((t * x2) >> 30) / 210;
    s  = s - longint'(t);
    if (s < 0) begin
      s = 0;
    end
    q = (s + 64'sd16384) >>> 15;
    if (q > 64'sd32767) begin
      q = 64'sd32767;
    end
    return SINE_W'(q);
  endfunction

endpackage

/* rtl/sdds_phase.sv */
`timescale 1ns / 1ps

module sdds_phase #(
  parameter int unsigned PHASE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  logic                         clr_i,
  input  logic [sdds_pkg::STEP_W-1:0]  step_i,
  output logic [PHASE_BITS-1:0]        phase_o
);

  logic [PHASE_BITS-1:0] mem_q [1];
  logic [PHASE_BITS-1:0] rd_q;
  logic [PHASE_BITS-1:0] wr_q;
  logic                  vld_q, vld_d;
  logic                  fwd_q, fwd_d;
  logic [PHASE_BITS-1:0] phase_nxt;

  // an invalid entry reads as zero; forward the write of the previous cycle
  assign phase_o   = !vld_q ? '0 : (fwd_q ? wr_q : rd_q);
  assign phase_nxt = phase_o + PHASE_BITS'(step_i);

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      mem_q[0] <= phase_nxt;
      wr_q     <= phase_nxt;
    end
    rd_q <= mem_q[0];
  end

  always_comb begin
    vld_d = vld_q;
    fwd_d = 1'b0;
    if (clr_i) begin
      vld_d = 1'b0;
    end else if (fire_i) begin
      vld_d = 1'b1;
      fwd_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      fwd_q <= fwd_d;
    end
  end

endmodule

/* rtl/sdds_sine_rom.sv */
`timescale 1ns / 1ps

module sdds_sine_rom #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [PHASE_BITS-1:0]        phase_i,
  output logic [sdds_pkg::SINE_W-1:0]  mag_o,
  output logic                         neg_o
);

  localparam int unsigned DEPTH = 1 << TABLE_ADDR_BITS;

  logic [sdds_pkg::SINE_W-1:0] rom [DEPTH];
  logic [1:0]                  quad;
  logic [TABLE_ADDR_BITS-1:0]  idx;
  logic [TABLE_ADDR_BITS-1:0]  addr;
  logic [sdds_pkg::SINE_W-1:0] mag_q;
  logic                        neg_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    assign rom[i] = sdds_pkg::rom_entry(i, TABLE_ADDR_BITS);
  end

  assign quad = phase_i[PHASE_BITS-1 -: 2];
  assign idx  = phase_i[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  // mirror the falling quarters
  assign addr = quad[0] ? ~idx : idx;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= rom[addr];
      neg_q <= quad[1];
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

/* rtl/sdds_scale.sv */
`timescale 1ns / 1ps

module sdds_scale #(
  parameter int unsigned DAC_BITS = 12
) (
  input  logic                         clk_i,
  input  sdds_pkg::pipe_en_t           en_i,
  input  logic [sdds_pkg::SINE_W-1:0]  mag_i,
  input  logic                         neg_i,
  input  logic [DAC_BITS-1:0]          amp_i,
  input  logic [DAC_BITS-1:0]          offset_i,
  output logic [DAC_BITS-1:0]          dac_o
);

  localparam int unsigned PROD_W = DAC_BITS + sdds_pkg::SINE_W;
  localparam int unsigned TOT_W  = PROD_W + 2;

  logic [PROD_W-1:0]        prod_q;
  logic                     neg_q;
  logic signed [TOT_W-1:0]  base;
  logic signed [TOT_W-1:0]  term;
  logic signed [TOT_W-1:0]  tot;
  logic [DAC_BITS:0]        hi;
  logic [DAC_BITS-1:0]      code;
  logic [DAC_BITS-1:0]      dac_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod_q <= PROD_W'(amp_i) * PROD_W'(mag_i);
      neg_q  <= neg_i;
    end
  end

  assign base = $signed({2'b00, offset_i, {sdds_pkg::Q_SHIFT{1'b0}}});
  assign term = $signed({2'b00, prod_q});
  assign tot  = neg_q ? (base - term) : (base + term);
  assign hi   = tot[sdds_pkg::Q_SHIFT +: DAC_BITS + 1];

  // clamp below zero and above full scale
  always_comb begin
    if (tot[TOT_W-1]) begin
      code = '0;
    end else if (hi[DAC_BITS]) begin
      code = '1;
    end else begin
      code = hi[DAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      dac_q <= code;
    end
  end

  assign dac_o = dac_q;

endmodule

/* rtl/sine_dds_dac_generator_top.sv */
`timescale 1ns / 1ps

// Sine generator for a DAC: every accepted tick item with tick high, while run is set,
// yields one dac_code item, offset plus amplitude times sine of the current phase,
// saturated to 0..2^DAC_BITS-1; the phase then advances by phase_step. Ticks are
// taken one per cycle while not stalled, through the ROM, product and code registers.
// The rate is set by the phase accumulator, a one-entry memory read every cycle and
// written on each fired tick, with the previous write forwarded; the sine comes from a registered
// quarter-wave ROM of 2^TABLE_ADDR_BITS entries and one multiplier stage follows.
// No clearing pass is needed after reset. Writing phase_step clears the phase;
// configure only while no item is in flight.
module sine_dds_dac_generator_top #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned DAC_BITS        = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             tick_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [DAC_BITS-1:0]              dac_code_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sdds_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sdds_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic [sdds_pkg::STEP_W-1:0] step_q, step_d;
  logic [DAC_BITS-1:0]         amp_q, amp_d;
  logic [DAC_BITS-1:0]         offset_q, offset_d;
  logic                        run_q, run_d;
  logic                        cfg_we;
  logic                        clr;

  logic                        v1_q, v2_q, v3_q;
  logic                        v1_d, v2_d, v3_d;
  sdds_pkg::pipe_en_t          en;
  logic                        fire;

  logic [PHASE_BITS-1:0]       phase;
  logic [sdds_pkg::SINE_W-1:0] mag;
  logic                        neg;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    step_d   = step_q;
    amp_d    = amp_q;
    offset_d = offset_q;
    run_d    = run_q;
    clr      = 1'b0;
    if (cfg_we) begin
      unique case (sdds_pkg::cfg_reg_e'(cfg_idx_i))
        sdds_pkg::REG_PHASE_STEP: begin
          step_d = sdds_pkg::STEP_W'(cfg_data_i);
          clr    = 1'b1;
        end
        sdds_pkg::REG_AMPLITUDE: amp_d    = DAC_BITS'(cfg_data_i);
        sdds_pkg::REG_OFFSET:    offset_d = DAC_BITS'(cfg_data_i);
        sdds_pkg::REG_RUN:       run_d    = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or the next one is moving
  assign en.s3      = !v3_q || !out_stall_i;
  assign en.s2      = !v2_q || en.s3;
  assign en.s1      = !v1_q || en.s2;
  assign in_stall_o = !en.s1;
  assign fire       = in_valid_i && en.s1 && tick_i && run_q;

  assign v1_d = en.s1 ? fire : v1_q;
  assign v2_d = en.s2 ? v1_q : v2_q;
  assign v3_d = en.s3 ? v2_q : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= sdds_pkg::PHASE_STEP_RST;
      amp_q    <= DAC_BITS'(sdds_pkg::LEVEL_RST);
      offset_q <= DAC_BITS'(sdds_pkg::LEVEL_RST);
      run_q    <= 1'b1;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
    end else begin
      step_q   <= step_d;
      amp_q    <= amp_d;
      offset_q <= offset_d;
      run_q    <= run_d;
      v1_q     <= v1_d;
      v2_q     <= v2_d;
      v3_q     <= v3_d;
    end
  end

  sdds_phase #(
    .PHASE_BITS(PHASE_BITS)
  ) u_phase (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .clr_i  (clr),
    .step_i (step_q),
    .phase_o(phase)
  );

  sdds_sine_rom #(
    .PHASE_BITS     (PHASE_BITS),
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_rom (
    .clk_i  (clk_i),
    .en_i   (en.s1),
    .phase_i(phase),
    .mag_o  (mag),
    .neg_o  (neg)
  );

  sdds_scale #(
    .DAC_BITS(DAC_BITS)
  ) u_scale (
    .clk_i   (clk_i),
    .en_i    (en),
    .mag_i   (mag),
    .neg_i   (neg),
    .amp_i   (amp_q),
    .offset_i(offset_q),
    .dac_o   (dac_code_o)
  );

  assign out_valid_o = v3_q;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned ADDR_W  = 10;
  localparam int unsigned CODE_W  = 12;
  localparam int unsigned SETTLE  = 8;
  localparam logic [CODE_W-1:0] CODE_MAX = 12'd4095;

  typedef struct {
    bit                 is_cfg;
    sdds_pkg::cfg_reg_e ridx;
    logic [31:0]        data;
    bit                 tick;
    bit                 known;
    logic [CODE_W-1:0]  code;
  } plan_row_t;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  logic                            tick_i      = 1'b0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [CODE_W-1:0]               dac_code_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [sdds_pkg::CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [sdds_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  // predicted block state
  logic [31:0]       step_q;
  logic [CODE_W-1:0] amp_q;
  logic [CODE_W-1:0] ofs_q;
  logic              run_q;
  logic [31:0]       phase_q;

  int                sine_lut [2**ADDR_W];
  logic [CODE_W-1:0] dac_expected [$];
  plan_row_t         plan [$];
  int                mismatch_cnt  = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       stall_pct     = 0;
  int unsigned       hold_left     = 0;
  bit                hold_req      = 1'b0;

  sine_dds_dac_generator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .tick_i      (tick_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dac_code_o  (dac_code_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // quarter-wave sample at the middle of table step i, Taylor series in Q30
  function automatic int quarter_sine(int unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          q;
    x    = (sdds_pkg::HALF_PI_Q30 * (64'(i) * 64'd2 + 64'd1)) >> (ADDR_W + 1);
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    q = (acc + 64'sd16384) >>> 15;
    if (q > 64'sd32767) begin
      q = 64'sd32767;
    end
    return int'(q);
  endfunction

  // returns 1 when the tick yields a sample; advances the phase
  function automatic bit next_dac_code(input bit t, output logic [CODE_W-1:0] code);
    logic [1:0]        quad;
    logic [ADDR_W-1:0] idx;
    int                s;
    longint            total;
    code = '0;
    if (!t || !run_q) begin
      return 1'b0;
    end
    quad = phase_q[31:30];
    idx  = phase_q[29 -: ADDR_W];
    if (quad[0]) begin
      idx = ~idx;
    end
    s = sine_lut[idx];
    if (quad[1]) begin
      s = -s;
    end
    total = (longint'(ofs_q) <<< 15) + longint'(amp_q) * longint'(s);
    if (total < 0) begin
      code = '0;
    end else if ((total >>> 15) > longint'(CODE_MAX)) begin
      code = CODE_MAX;
    end else begin
      code = CODE_W'(total >>> 15);
    end
    phase_q = phase_q + step_q;
    return 1'b1;
  endfunction

  // receiver: random stall, or a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i = 1'b1;
      hold_left   = hold_left - 1;
    end else if (hold_req) begin
      hold_req    = 1'b0;
      hold_left   = 59;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    logic [CODE_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (dac_expected.size() == 0) begin
        if (mismatch_cnt < 10) begin
          $display("unexpected dac_code %0d at %0t", dac_code_o, $realtime);
        end
        mismatch_cnt++;
      end else begin
        want = dac_expected.pop_front();
        if (dac_code_o !== want) begin
          if (mismatch_cnt < 10) begin
            $display("dac_code mismatch at %0t: expected %0d, got %0d",
                     $realtime, want, dac_code_o);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  task automatic send_tick(input bit t, input bit known = 1'b0,
                           input logic [CODE_W-1:0] lit = '0);
    logic [CODE_W-1:0] code;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    tick_i     = t;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    if (next_dac_code(t, code)) begin
      dac_expected.push_back(known ? lit : code);
    end
  endtask

  // drop valid, drain all expected samples, then let the pipeline empty
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (dac_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input sdds_pkg::cfg_reg_e ridx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_idx_i   = ridx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    unique case (ridx)
      sdds_pkg::REG_PHASE_STEP: begin
        step_q  = data;
        phase_q = '0;
      end
      sdds_pkg::REG_AMPLITUDE: amp_q = data[CODE_W-1:0];
      sdds_pkg::REG_OFFSET:    ofs_q = data[CODE_W-1:0];
      sdds_pkg::REG_RUN:       run_q = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic plan_row_t cfg_row(sdds_pkg::cfg_reg_e ridx, logic [31:0] data);
    plan_row_t r;
    r = '{1'b1, ridx, data, 1'b0, 1'b0, '0};
    return r;
  endfunction

  function automatic plan_row_t tick_row(bit t, bit known = 1'b0,
                                         logic [CODE_W-1:0] code = '0);
    plan_row_t r;
    r = '{1'b0, sdds_pkg::REG_RUN, '0, t, known, code};
    return r;
  endfunction

  function automatic logic [31:0] rand_step();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(32'h8000_0000, 0);
      2: return $urandom_range(65535, 1);
      3: begin
        case ($urandom_range(2))
          0: return 32'h0;
          1: return 32'h8000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom_range(32'h1000_0000, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_level();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = 32'd0;
      1: v = 32'd4095;
      2: v = 32'd2048;
      default: v = $urandom_range(4095);
    endcase
    // upper bits are dropped by the block
    return {$urandom} & 32'hFFFF_F000 | v;
  endfunction

  initial begin
    int unsigned count;
    bit          t;
    step_q  = sdds_pkg::PHASE_STEP_RST;
    amp_q   = CODE_W'(sdds_pkg::LEVEL_RST);
    ofs_q   = CODE_W'(sdds_pkg::LEVEL_RST);
    run_q   = 1'b1;
    phase_q = '0;
    for (int i = 0; i < 2**ADDR_W; i++) begin
      sine_lut[i] = quarter_sine(i);
    end

    plan.push_back(tick_row(1'b1));
    plan.push_back(tick_row(1'b0));
    plan.push_back(tick_row(1'b1));
    plan.push_back(cfg_row(sdds_pkg::REG_AMPLITUDE, 32'hFFFF_F000));
    plan.push_back(tick_row(1'b1, 1'b1, 12'd2048));
    plan.push_back(cfg_row(sdds_pkg::REG_OFFSET, 32'd4095));
    plan.push_back(cfg_row(sdds_pkg::REG_AMPLITUDE, 32'd4095));
    plan.push_back(cfg_row(sdds_pkg::REG_PHASE_STEP, 32'h0));
    plan.push_back(tick_row(1'b1, 1'b1, CODE_MAX));
    plan.push_back(tick_row(1'b1, 1'b1, CODE_MAX));
    plan.push_back(cfg_row(sdds_pkg::REG_OFFSET, 32'd0));
    plan.push_back(cfg_row(sdds_pkg::REG_PHASE_STEP, 32'h8000_0000));
    plan.push_back(tick_row(1'b1));
    plan.push_back(tick_row(1'b1, 1'b1, 12'd0));
    plan.push_back(tick_row(1'b0));
    plan.push_back(tick_row(1'b1));
    plan.push_back(cfg_row(sdds_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF));
    plan.push_back(tick_row(1'b1));
    plan.push_back(tick_row(1'b1));
    plan.push_back(cfg_row(sdds_pkg::REG_OFFSET, 32'd2048));
    plan.push_back(cfg_row(sdds_pkg::REG_PHASE_STEP, 32'h4000_0000));
    repeat (4) plan.push_back(tick_row(1'b1));
    plan.push_back(cfg_row(sdds_pkg::REG_RUN, 32'hFFFF_FFFE));
    plan.push_back(tick_row(1'b1));
    plan.push_back(tick_row(1'b1));
    plan.push_back(cfg_row(sdds_pkg::REG_RUN, 32'h1));
    plan.push_back(tick_row(1'b1));
    plan.push_back(cfg_row(sdds_pkg::REG_AMPLITUDE, 32'd0));
    plan.push_back(cfg_row(sdds_pkg::REG_OFFSET, 32'd4095));
    plan.push_back(tick_row(1'b1, 1'b1, CODE_MAX));
    plan.push_back(cfg_row(sdds_pkg::REG_OFFSET, 32'd0));
    plan.push_back(tick_row(1'b1, 1'b1, 12'd0));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].ridx, plan[i].data);
      end else begin
        send_tick(plan[i].tick, plan[i].known, plan[i].code);
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      settle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 69; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 69; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      if ($urandom_range(3) != 0) begin
        write_reg(sdds_pkg::REG_PHASE_STEP, rand_step());
      end
      write_reg(sdds_pkg::REG_AMPLITUDE, rand_level());
      write_reg(sdds_pkg::REG_OFFSET, rand_level());
      if (ph % 4 == 3) begin
        // ticks are ignored while stopped
        write_reg(sdds_pkg::REG_RUN, {$urandom} & 32'hFFFF_FFFE);
        repeat (8) send_tick(1'($urandom_range(1)));
        settle();
        write_reg(sdds_pkg::REG_RUN, {$urandom} | 32'h1);
      end
      if (ph == 4) begin
        hold_req = 1'b1;
      end
      count = 0;
      while (count < 133) begin
        t = ($urandom_range(9) != 0);
        send_tick(t);
        if (t) begin
          count++;
        end
        if (ph == 6 && count == 75) begin
          @(negedge clk_i);
          in_valid_i = 1'b0;
          while (dac_expected.size() != 0) begin
            @(posedge clk_i);
          end
        end
      end
    end

    settle();
    if (mismatch_cnt == 0 && dac_expected.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/sdds_pkg.sv
rtl/sdds_phase.sv
rtl/sdds_sine_rom.sv
rtl/sdds_scale.sv
rtl/sine_dds_dac_generator_top.sv
bench/testbench.sv
